### rtl/rhvp_pkg.sv
// shared types and constants for the record header varint parser
`default_nettype none

package rhvp_pkg;

  localparam int MAX_COLUMNS_DEFAULT = 32;

  localparam int REC_LENGTH_W = 32;
  localparam int SERIAL_TYPE_W = 64;
  localparam int SIZE_W = 32;
  localparam int COL_INDEX_W = 5;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_HLEN  = 3'd1,
    ST_OVERRUN   = 3'd2,
    ST_TOO_MANY  = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0]              rec_byte;
    logic                    rec_start;
    logic [REC_LENGTH_W-1:0] rec_length;
  } in_t;

  typedef struct packed {
    logic [COL_INDEX_W-1:0]   col_index;
    logic [SERIAL_TYPE_W-1:0] serial_type;
    logic [SIZE_W-1:0]        content_size;
    logic [SIZE_W-1:0]        content_offset;
    logic                     col_valid;
    logic                     last;
    status_t                  status;
  } out_t;

endpackage

`default_nettype wire

### rtl/rhvp_decode.sv
// per-byte varint decode, header bookkeeping and result formation
`default_nettype none

module rhvp_decode #(
  parameter int MAX_COLUMNS = rhvp_pkg::MAX_COLUMNS_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  rhvp_pkg::in_t   item,
  output logic            res_present,
  output rhvp_pkg::out_t  res
);

  localparam int CW = $clog2(MAX_COLUMNS + 1);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HLEN,
    PH_COLS
  } phase_t;

  phase_t      phase, phase_next, cur_phase;
  logic [63:0] accum, accum_next, cur_accum;
  logic [3:0]  vbytes, vbytes_next, cur_vbytes;
  logic [31:0] hlen, hlen_next, cur_hlen;
  logic [31:0] bpos, bpos_next, cur_bpos;
  logic [CW-1:0] ccount, ccount_next, cur_ccount;
  logic [31:0] roff, roff_next, cur_roff;
  logic [31:0] limit, limit_next, cur_limit;

  logic [63:0] fed;
  logic        done;
  logic        ninth;
  logic [31:0] pos;
  logic [31:0] size;
  logic [32:0] sum;

  function automatic logic [31:0] small_size(input logic [3:0] st);
    logic [31:0] r;
    unique case (st)
      4'd1:    r = 32'd1;
      4'd2:    r = 32'd2;
      4'd3:    r = 32'd3;
      4'd4:    r = 32'd4;
      4'd5:    r = 32'd6;
      4'd6:    r = 32'd8;
      4'd7:    r = 32'd8;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] serial_size(input logic [63:0] st);
    logic [62:0] half;
    logic [31:0] r;
    half = st[63:1] - 63'd6;
    if (st[63:4] == 60'd0 && st[3:0] < 4'd12) begin
      r = small_size(st[3:0]);
    end else if (half[62:32] != 31'd0) begin
      r = '1;
    end else begin
      r = half[31:0];
    end
    return r;
  endfunction

  always_comb begin
    cur_phase  = phase;
    cur_accum  = accum;
    cur_vbytes = vbytes;
    cur_hlen   = hlen;
    cur_bpos   = bpos;
    cur_ccount = ccount;
    cur_roff   = roff;
    cur_limit  = limit;
    if (item.rec_start) begin
      cur_phase  = PH_HLEN;
      cur_accum  = '0;
      cur_vbytes = '0;
      cur_hlen   = '0;
      cur_bpos   = '0;
      cur_ccount = '0;
      cur_roff   = '0;
      cur_limit  = item.rec_length;
    end

    ninth = (cur_vbytes >= 4'd8);
    fed   = ninth ? {cur_accum[55:0], item.rec_byte}
                  : {cur_accum[56:0], item.rec_byte[6:0]};
    done  = ninth || !item.rec_byte[7];
    pos   = cur_bpos + 32'd1;
    size  = serial_size(fed);
    sum   = {1'b0, cur_roff} + {1'b0, size};

    phase_next  = cur_phase;
    accum_next  = cur_accum;
    vbytes_next = cur_vbytes;
    hlen_next   = cur_hlen;
    bpos_next   = cur_bpos;
    ccount_next = cur_ccount;
    roff_next   = cur_roff;
    limit_next  = cur_limit;
    res_present = 1'b0;
    res         = '0;

    if (item.rec_start && item.rec_length == '0) begin
      phase_next  = PH_IDLE;
      res_present = 1'b1;
      res.last    = 1'b1;
      res.status  = rhvp_pkg::ST_EMPTY;
    end else if (cur_phase != PH_IDLE) begin
      accum_next  = done ? 64'd0 : fed;
      vbytes_next = done ? 4'd0 : cur_vbytes + 4'd1;
      bpos_next   = pos;
      if (cur_phase == PH_HLEN) begin
        if (!done) begin
          if (pos >= cur_limit) begin
            phase_next  = PH_IDLE;
            res_present = 1'b1;
            res.last    = 1'b1;
            res.status  = rhvp_pkg::ST_BAD_HLEN;
          end
        end else if (fed[63:32] != 32'd0 || fed[31:0] == 32'd0
                     || fed[31:0] > cur_limit) begin
          phase_next  = PH_IDLE;
          res_present = 1'b1;
          res.last    = 1'b1;
          res.status  = rhvp_pkg::ST_BAD_HLEN;
        end else begin
          hlen_next = fed[31:0];
          roff_next = fed[31:0];
          if (pos > fed[31:0]) begin
            phase_next  = PH_IDLE;
            res_present = 1'b1;
            res.last    = 1'b1;
            res.status  = rhvp_pkg::ST_OVERRUN;
          end else if (pos == fed[31:0]) begin
            phase_next  = PH_IDLE;
            res_present = 1'b1;
            res.last    = 1'b1;
            res.status  = rhvp_pkg::ST_OK;
          end else begin
            phase_next = PH_COLS;
          end
        end
      end else begin
        if (!done) begin
          if (pos >= cur_hlen) begin
            phase_next  = PH_IDLE;
            res_present = 1'b1;
            res.last    = 1'b1;
            res.status  = rhvp_pkg::ST_OVERRUN;
          end
        end else begin
          roff_next          = sum[32] ? '1 : sum[31:0];
          ccount_next        = cur_ccount + CW'(1);
          res_present        = 1'b1;
          res.col_valid      = 1'b1;
          res.col_index      = rhvp_pkg::COL_INDEX_W'(cur_ccount);
          res.serial_type    = fed;
          res.content_size   = size;
          res.content_offset = cur_roff;
          res.status         = rhvp_pkg::ST_OK;
          if (pos >= cur_hlen) begin
            res.last   = 1'b1;
            phase_next = PH_IDLE;
          end else if (ccount_next >= CW'(MAX_COLUMNS)) begin
            res.last   = 1'b1;
            res.status = rhvp_pkg::ST_TOO_MANY;
            phase_next = PH_IDLE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_IDLE;
      accum  <= '0;
      vbytes <= '0;
      hlen   <= '0;
      bpos   <= '0;
      ccount <= '0;
      roff   <= '0;
      limit  <= '0;
    end else if (take) begin
      phase  <= phase_next;
      accum  <= accum_next;
      vbytes <= vbytes_next;
      hlen   <= hlen_next;
      bpos   <= bpos_next;
      ccount <= ccount_next;
      roff   <= roff_next;
      limit  <= limit_next;
    end
  end

endmodule

`default_nettype wire

### rtl/record_header_varint_parser.sv
// top level: input register, decode step and result register
//
//   channel  | valid      | stall      | payload
//   ---------+------------+------------+-----------------------
//   record   | rec_valid  | rec_stall  | rec_item (one byte)
//   header   | hdr_valid  | hdr_stall  | hdr_item (one result)
//
// one byte per cycle sustained while the header channel is not stalled; a result
// is formed from its byte while the byte waits in the input register, then one
// decode step fills the result register
// reset clears the handshake flags and the parser state; no clearing pass
// rec_stall rises only while a byte is held and the result register is stalled
`default_nettype none

module record_header_varint_parser #(
  parameter int MAX_COLUMNS = rhvp_pkg::MAX_COLUMNS_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            rec_valid,
  output logic            rec_stall,
  input  rhvp_pkg::in_t   rec_item,
  output logic            hdr_valid,
  input  logic            hdr_stall,
  output rhvp_pkg::out_t  hdr_item
);

  logic           item_full;
  rhvp_pkg::in_t  item;
  logic           advance;
  logic           take;
  logic           res_present;
  rhvp_pkg::out_t res;

  assign advance   = !hdr_valid || !hdr_stall;
  assign rec_stall = item_full && !advance;
  assign take      = item_full && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (rec_valid && !rec_stall) begin
      item_full <= 1'b1;
    end else if (advance) begin
      item_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_valid && !rec_stall) begin
      item <= rec_item;
    end
  end

  rhvp_decode #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_decode (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .item        (item),
    .res_present (res_present),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_valid <= 1'b0;
    end else if (take && res_present) begin
      hdr_valid <= 1'b1;
    end else if (!hdr_stall) begin
      hdr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_present) begin
      hdr_item <= res;
    end
  end

`ifndef SYNTHESIS
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    rec_stall |-> item_full)
    else $error("stall raised with no byte held");

  a_noncol_is_last: assert property (@(posedge clk) disable iff (rst)
    hdr_valid && !hdr_item.col_valid |-> hdr_item.last)
    else $error("non-column result without last");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    hdr_valid && hdr_item.status != rhvp_pkg::ST_OK |-> hdr_item.last)
    else $error("error status without last");

  a_col_status: assert property (@(posedge clk) disable iff (rst)
    hdr_valid && hdr_item.col_valid
      |-> hdr_item.status == rhvp_pkg::ST_OK || hdr_item.status == rhvp_pkg::ST_TOO_MANY)
    else $error("column result with a header error status");
`endif

endmodule

`default_nettype wire
